/* rtl/olir_pkg.sv */
package olir_pkg;

    // Port field widths fixed by the interface
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int LEN_W  = 7;
    localparam int ELEM_MAX_W = 64;

    // Action codes
    typedef enum logic [2:0] {
        ACT_INSERT     = 3'd0,
        ACT_REMOVE     = 3'd1,
        ACT_PUSH       = 3'd2,
        ACT_POP        = 3'd3,
        ACT_REMOVE_ALL = 3'd4,
        ACT_CONTAINS   = 3'd5,
        ACT_CLEAR      = 3'd6,
        ACT_READ       = 3'd7
    } action_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

endpackage

/* rtl/ordered_list_insert_remove_core.sv */
// Pop, clear, push, insert at the end, a remove of the last element, every error and
// remove_all or contains on an empty list finish at accept: busy stays low and done pulses in the next cycle.
// Other actions walk the element RAM with busy high, one read per cycle, reading k elements,
// k = n-p (insert), n-p-1 (remove), n (remove_all, contains), 1 (read); done follows.
// Reset empties the list (count to zero); RAM contents are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module ordered_list_insert_remove_core #(
    parameter int ELEM_WIDTH = 32,
    parameter int DEPTH      = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  action,
    input  logic [6:0]  position,
    input  logic [31:0] value,
    output logic        done,
    output logic [1:0]  status,
    output logic        found,
    output logic [6:0]  removed_count,
    output logic [6:0]  length,
    output logic [31:0] read_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > olir_pkg::POS_W) ? CW : olir_pkg::POS_W;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t                  state_reg;
    olir_pkg::action_t       op_reg;
    logic [CW-1:0]           count_reg;
    logic [AW-1:0]           rp_reg;
    logic [AW-1:0]           stop_reg;
    logic [AW-1:0]           raddr_q_reg;
    logic [AW-1:0]           pos_reg;
    logic                    issue_reg;
    logic                    rvld_reg;
    logic [CW-1:0]           wp_reg;
    logic [CW-1:0]           hits_reg;
    logic                    hit_reg;
    logic [ELEM_WIDTH-1:0]   val_reg;

    logic                    done_reg;
    olir_pkg::status_t       status_reg;
    logic                    found_reg;
    logic [6:0]              removed_reg;
    logic [6:0]              length_reg;
    logic [31:0]             data_reg;

    // RAM port signals
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [ELEM_WIDTH-1:0]   ram_wdata;
    logic [ELEM_WIDTH-1:0]   ram_rdata;

    olir_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rp_reg),
        .rdata (ram_rdata)
    );

    // Common derived values
    olir_pkg::action_t       act;
    logic                    accept;
    logic [MW-1:0]           pos_m;
    logic [MW-1:0]           cnt_m;
    logic [MW-1:0]           ipos;
    logic [CW-1:0]           cnt_m1;
    logic [AW-1:0]           last_a;
    logic [63:0]             value64;
    logic [ELEM_WIDTH-1:0]   val_e;
    logic [63:0]             hold64;
    logic                    full;
    logic                    match;
    logic                    drained;
    logic [AW-1:0]           rp_step;

    assign act     = olir_pkg::action_t'(action);
    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && (state_reg == S_IDLE);
    assign pos_m   = MW'(position);
    assign cnt_m   = MW'(count_reg);
    assign ipos    = (act == olir_pkg::ACT_PUSH) ? cnt_m : pos_m;
    assign cnt_m1  = count_reg - CW'(1);
    assign last_a  = cnt_m1[AW-1:0];
    assign value64 = 64'(value);
    assign val_e   = value64[ELEM_WIDTH-1:0];
    assign hold64  = 64'(val_reg);
    assign full    = (count_reg == CW'(DEPTH));
    assign match   = (ram_rdata == val_reg);
    assign drained = !issue_reg && !rvld_reg;
    assign rp_step = (op_reg == olir_pkg::ACT_INSERT) ? (rp_reg - AW'(1)) : (rp_reg + AW'(1));

    // Decode of an accepted command
    olir_pkg::status_t       dec_status;
    logic [CW-1:0]           dec_count;
    logic                    dec_run;
    logic                    dec_we;
    logic [AW-1:0]           dec_rp;
    logic [AW-1:0]           dec_stop;

    always_comb
    begin
        dec_status = olir_pkg::STAT_OK;
        dec_count  = count_reg;
        dec_run    = 1'b0;
        dec_we     = 1'b0;
        dec_rp     = '0;
        dec_stop   = '0;
        unique case (act)
            olir_pkg::ACT_INSERT, olir_pkg::ACT_PUSH:
            begin
                if (ipos > cnt_m)
                begin
                    dec_status = olir_pkg::STAT_RANGE;
                end
                else if (full)
                begin
                    dec_status = olir_pkg::STAT_FULL;
                end
                else if (ipos == cnt_m)
                begin
                    dec_we    = 1'b1;
                    dec_count = count_reg + CW'(1);
                end
                else
                begin
                    dec_run  = 1'b1;
                    dec_rp   = last_a;
                    dec_stop = ipos[AW-1:0];
                end
            end
            olir_pkg::ACT_REMOVE:
            begin
                if (pos_m >= cnt_m)
                begin
                    dec_status = olir_pkg::STAT_RANGE;
                end
                else if (pos_m[AW-1:0] == last_a)
                begin
                    dec_count = cnt_m1;
                end
                else
                begin
                    dec_run  = 1'b1;
                    dec_rp   = pos_m[AW-1:0] + AW'(1);
                    dec_stop = last_a;
                end
            end
            olir_pkg::ACT_POP:
            begin
                if (count_reg == '0)
                begin
                    dec_status = olir_pkg::STAT_EMPTY;
                end
                else
                begin
                    dec_count = cnt_m1;
                end
            end
            olir_pkg::ACT_REMOVE_ALL, olir_pkg::ACT_CONTAINS:
            begin
                if (count_reg != '0)
                begin
                    dec_run  = 1'b1;
                    dec_rp   = '0;
                    dec_stop = last_a;
                end
            end
            olir_pkg::ACT_CLEAR:
            begin
                dec_count = '0;
            end
            olir_pkg::ACT_READ:
            begin
                if (pos_m >= cnt_m)
                begin
                    dec_status = olir_pkg::STAT_RANGE;
                end
                else
                begin
                    dec_run  = 1'b1;
                    dec_rp   = pos_m[AW-1:0];
                    dec_stop = pos_m[AW-1:0];
                end
            end
            default:
            begin
                dec_status = olir_pkg::STAT_OK;
            end
        endcase
    end

    // RAM write port: direct append, shift moves, compaction, final insert
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = raddr_q_reg;
        ram_wdata = ram_rdata;
        if (state_reg == S_IDLE)
        begin
            if (accept && dec_we)
            begin
                ram_we    = 1'b1;
                ram_waddr = count_reg[AW-1:0];
                ram_wdata = val_e;
            end
        end
        else if (rvld_reg)
        begin
            case (op_reg)
                olir_pkg::ACT_INSERT:
                begin
                    ram_we    = 1'b1;
                    ram_waddr = raddr_q_reg + AW'(1);
                end
                olir_pkg::ACT_REMOVE:
                begin
                    ram_we    = 1'b1;
                    ram_waddr = raddr_q_reg - AW'(1);
                end
                olir_pkg::ACT_REMOVE_ALL:
                begin
                    ram_we    = !match;
                    ram_waddr = wp_reg[AW-1:0];
                end
                default:
                begin
                    ram_we = 1'b0;
                end
            endcase
        end
        else if (drained && (op_reg == olir_pkg::ACT_INSERT))
        begin
            ram_we    = 1'b1;
            ram_waddr = pos_reg;
            ram_wdata = val_reg;
        end
    end

    // Element count at the end of a RAM walk
    logic [CW-1:0] fin_count;

    always_comb
    begin
        case (op_reg)
            olir_pkg::ACT_INSERT:     fin_count = count_reg + CW'(1);
            olir_pkg::ACT_REMOVE:     fin_count = cnt_m1;
            olir_pkg::ACT_REMOVE_ALL: fin_count = wp_reg;
            default:                  fin_count = count_reg;
        endcase
    end

    // Sequencer state and registered results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            op_reg      <= olir_pkg::ACT_INSERT;
            count_reg   <= '0;
            rp_reg      <= '0;
            stop_reg    <= '0;
            raddr_q_reg <= '0;
            pos_reg     <= '0;
            issue_reg   <= 1'b0;
            rvld_reg    <= 1'b0;
            wp_reg      <= '0;
            hits_reg    <= '0;
            hit_reg     <= 1'b0;
            val_reg     <= '0;
            done_reg    <= 1'b0;
            status_reg  <= olir_pkg::STAT_OK;
            found_reg   <= 1'b0;
            removed_reg <= '0;
            length_reg  <= '0;
            data_reg    <= '0;
        end
        else
        begin
            // Strobe for a command finished at accept or at the end of a walk
            done_reg <= (state_reg == S_IDLE) ? (accept && !dec_run) : drained;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg   <= act;
                        pos_reg  <= ipos[AW-1:0];
                        val_reg  <= val_e;
                        rp_reg   <= dec_rp;
                        stop_reg <= dec_stop;
                        wp_reg   <= '0;
                        hits_reg <= '0;
                        hit_reg  <= 1'b0;
                        rvld_reg <= 1'b0;
                        if (dec_run)
                        begin
                            state_reg <= S_RUN;
                            issue_reg <= 1'b1;
                        end
                        else
                        begin
                            count_reg   <= dec_count;
                            status_reg  <= dec_status;
                            found_reg   <= 1'b0;
                            removed_reg <= '0;
                            length_reg  <= 7'(dec_count);
                            data_reg    <= '0;
                        end
                    end
                end
                S_RUN:
                begin
                    // Read issue: one address per cycle toward the stop address
                    rvld_reg    <= issue_reg;
                    raddr_q_reg <= rp_reg;
                    if (issue_reg)
                    begin
                        if (rp_reg == stop_reg)
                        begin
                            issue_reg <= 1'b0;
                        end
                        else
                        begin
                            rp_reg <= rp_step;
                        end
                    end
                    // Returned data
                    if (rvld_reg)
                    begin
                        case (op_reg)
                            olir_pkg::ACT_REMOVE_ALL:
                            begin
                                if (match)
                                begin
                                    hits_reg <= hits_reg + CW'(1);
                                end
                                else
                                begin
                                    wp_reg <= wp_reg + CW'(1);
                                end
                            end
                            olir_pkg::ACT_CONTAINS:
                            begin
                                if (match)
                                begin
                                    hit_reg <= 1'b1;
                                end
                            end
                            olir_pkg::ACT_READ:
                            begin
                                val_reg <= ram_rdata;
                            end
                            default:
                            begin
                                hit_reg <= hit_reg;
                            end
                        endcase
                    end
                    // Pipeline empty: commit and report
                    if (drained)
                    begin
                        state_reg   <= S_IDLE;
                        count_reg   <= fin_count;
                        status_reg  <= olir_pkg::STAT_OK;
                        found_reg   <= (op_reg == olir_pkg::ACT_CONTAINS) && hit_reg;
                        removed_reg <= (op_reg == olir_pkg::ACT_REMOVE_ALL) ? 7'(hits_reg)
                                                                            : 7'd0;
                        length_reg  <= 7'(fin_count);
                        data_reg    <= (op_reg == olir_pkg::ACT_READ) ? hold64[31:0] : 32'd0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign found         = found_reg;
    assign removed_count = removed_reg;
    assign length        = length_reg;
    assign read_data     = data_reg;

    // Element count never exceeds capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count above capacity");

    // No RAM write while idle unless a command is being taken
    a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !accept) |-> !ram_we)
        else $error("RAM write while idle");

    // Compaction write pointer never passes the element just read
    a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN && op_reg == olir_pkg::ACT_REMOVE_ALL && rvld_reg)
            |-> (wp_reg <= CW'(raddr_q_reg)))
        else $error("compaction overtook read pointer");

    // Every result strobe follows a finished command
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(accept) && !$past(dec_run))
                     || ($past(state_reg == S_RUN) && $past(drained)))
        else $error("result strobe without finished command");

    // A walk always ends back in idle with a result
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN && drained) |=> (state_reg == S_IDLE && done_reg))
        else $error("walk did not complete");

endmodule

/* rtl/olir_ram.sv */
module olir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
